[design/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg: shared types for the bucketed hash set
// transaction payloads, operation and status codes, back-end states
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int KEY_W = 31;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;
    localparam int BKT_W = 4;

    // operation code 3 is unused and behaves as a search that never hits
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_DELETED   = 3'd5,
        ST_ABSENT    = 3'd6
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [BKT_W-1:0] bucket;
    } t_res;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_LAST,
        BK_DONE
    } t_bk_state;

endpackage

[design/bucketed_hash_set_unit.sv]
// ----------------------------------------------------------------------------
// bucketed_hash_set_unit: set of 31-bit keys in BUCKETS x WAYS hashed slots
// insert, search and delete by key, with a status and bucket per transaction
// ----------------------------------------------------------------------------
// A key lives in bucket (key mod BUCKETS), which holds WAYS slots. Each request
// transaction gives exactly one result transaction, in order. After reset the
// slot table is swept empty, one slot per cycle, and full stays high during
// that sweep. The front end reduces the key modulo BUCKETS, then hands the job
// on; it accepts no new transaction until it has handed on the last job. The
// back end reads the bucket's ways one per cycle from a single-read-port slot
// memory, then writes at most one slot and loads the result register, and only
// then takes the next job. A two-entry job queue between the two ends absorbs
// stalls on either side, and the result register lets the next job run while
// a result waits.
// ----------------------------------------------------------------------------
module bucketed_hash_set_unit #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request side, queue-like
    input  logic          push,
    output logic          full,
    input  hbs_pkg::t_req i_req,
    // result side, queue-like
    output logic          empty,
    input  logic          pop,
    output hbs_pkg::t_res o_res
);

    // bucket index width and slot address width
    localparam int RW = $clog2(BUCKETS);
    localparam int AW = $clog2(BUCKETS * WAYS);
    // job word: operation, key, bucket index, first slot address of the bucket
    localparam int JW = hbs_pkg::OP_W + hbs_pkg::KEY_W + RW + AW;

    logic          job_push;
    logic [JW-1:0] job_in;
    logic          job_full;
    logic          job_pop;
    logic [JW-1:0] job_out;
    logic          job_empty;
    logic          clearing;

    // front end: takes request transactions and works out the bucket
    hbs_front #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .RW      (RW),
        .AW      (AW),
        .JW      (JW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_req      (i_req),
        .i_hold     (clearing),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    // short queue so the two ends stall independently
    hbs_fifo #(
        .W (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // back end: slot table scan, update and result register
    hbs_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .RW      (RW),
        .AW      (AW),
        .JW      (JW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (o_res)
    );

endmodule

[design/hbs_fifo.sv]
// ----------------------------------------------------------------------------
// hbs_fifo: two-entry job queue
// decouples the classifying front end from the table back end
// ----------------------------------------------------------------------------
module hbs_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[design/hbs_front.sv]
// ----------------------------------------------------------------------------
// hbs_front: request intake and bucket classification
// reduces the key modulo the bucket count, eight key bits per cycle
// ----------------------------------------------------------------------------
module hbs_front #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4,
    parameter int RW      = $clog2(BUCKETS),
    parameter int AW      = $clog2(BUCKETS * WAYS),
    parameter int JW      = hbs_pkg::OP_W + hbs_pkg::KEY_W + RW + AW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  hbs_pkg::t_req i_req,
    input  logic          i_hold,
    output logic          o_job_push,
    output logic [JW-1:0] o_job,
    input  logic          i_job_full
);

    localparam logic [RW:0] BK = (RW + 1)'(BUCKETS);

    logic                        r_busy;
    logic                        r_done;
    logic [1:0]                  r_cnt;
    logic [RW-1:0]               r_rem;
    logic [hbs_pkg::OP_W-1:0]    r_op;
    logic [hbs_pkg::KEY_W-1:0]   r_key;
    logic [RW-1:0]               n_rem;
    logic [31:0]                 key_pad;
    logic [7:0]                  cur_digit;
    logic [AW-1:0]               base;
    logic                        accept;

    assign o_job_push = r_busy && r_done && !i_job_full;
    assign o_full     = i_hold || (r_busy && !o_job_push);
    assign accept     = i_push && !o_full;
    assign key_pad    = {1'b0, r_key};
    assign cur_digit  = key_pad[31 - 8 * r_cnt -: 8];
    assign base       = AW'(r_rem * WAYS);
    assign o_job      = {r_op, r_key, r_rem, base};

    // long division, one key bit per step, remainder stays below the bucket count
    always_comb begin
        logic [RW:0]   t;
        logic [RW-1:0] rem;
        rem = r_rem;
        t   = '0;
        for (int i = 0; i < 8; i++) begin
            t = {rem, cur_digit[7 - i]};
            if (t >= BK) begin
                t = t - BK;
            end
            rem = t[RW-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.operation;
            r_key <= i_req.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
            r_rem  <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= 2'd0;
                r_rem  <= '0;
            end else if (o_job_push) begin
                r_busy <= 1'b0;
            end else if (r_busy && !r_done) begin
                r_rem <= n_rem;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[design/hbs_back.sv]
// ----------------------------------------------------------------------------
// hbs_back: slot table and request execution
// scans one bucket way per cycle, then commits at most one slot write and the result
// ----------------------------------------------------------------------------
module hbs_back #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4,
    parameter int RW      = $clog2(BUCKETS),
    parameter int AW      = $clog2(BUCKETS * WAYS),
    parameter int JW      = hbs_pkg::OP_W + hbs_pkg::KEY_W + RW + AW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [JW-1:0] i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    output logic          o_clearing,
    output logic          o_empty,
    input  logic          i_pop,
    output hbs_pkg::t_res o_res
);

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int WCW   = $clog2(WAYS + 1);

    hbs_pkg::t_slot r_slot [SLOTS];
    hbs_pkg::t_slot r_rd;

    hbs_pkg::t_bk_state        r_state, n_state;
    logic [hbs_pkg::OP_W-1:0]  r_op, n_op;
    logic [hbs_pkg::KEY_W-1:0] r_key, n_key;
    logic [RW-1:0]             r_bkt, n_bkt;
    logic [AW-1:0]             r_base, n_base;
    logic [WCW-1:0]            r_way, n_way;
    logic                      r_pend, n_pend;
    logic [WCW-1:0]            r_pway, n_pway;
    logic                      r_hit, n_hit;
    logic [WCW-1:0]            r_hway, n_hway;
    logic                      r_free, n_free;
    logic [WCW-1:0]            r_fway, n_fway;
    logic [AW-1:0]             r_clr, n_clr;
    logic                      r_out_vld, n_out_vld;
    hbs_pkg::t_res             r_out, n_out;

    logic [hbs_pkg::OP_W-1:0]  job_op;
    logic [hbs_pkg::KEY_W-1:0] job_key;
    logic [RW-1:0]             job_bkt;
    logic [AW-1:0]             job_base;
    logic [RW+3:0]             bkt_ext;

    logic                      ren;
    logic [AW-1:0]             raddr;
    logic                      wen;
    logic [AW-1:0]             waddr;
    hbs_pkg::t_slot            wdata;

    assign {job_op, job_key, job_bkt, job_base} = i_job;
    assign bkt_ext    = {4'b0, r_bkt};
    assign o_clearing = (r_state == hbs_pkg::BK_CLEAR);
    assign o_empty    = !r_out_vld;
    assign o_res      = r_out;

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_slot[waddr] <= wdata;
        end
        if (ren) begin
            r_rd <= r_slot[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_bkt  <= n_bkt;
        r_base <= n_base;
        r_pway <= n_pway;
        r_hway <= n_hway;
        r_fway <= n_fway;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hbs_pkg::BK_CLEAR;
            r_way     <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_way     <= n_way;
            r_pend    <= n_pend;
            r_hit     <= n_hit;
            r_free    <= n_free;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_bkt     = r_bkt;
        n_base    = r_base;
        n_way     = r_way;
        n_pend    = 1'b0;
        n_pway    = r_pway;
        n_hit     = r_hit;
        n_hway    = r_hway;
        n_free    = r_free;
        n_fway    = r_fway;
        n_clr     = r_clr;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        o_job_pop = 1'b0;
        ren       = 1'b0;
        raddr     = '0;
        wen       = 1'b0;
        waddr     = '0;
        wdata     = '0;

        // compare the way read in the previous cycle; ways arrive in order
        if (r_pend) begin
            if (r_rd.valid && (r_rd.key == r_key) && !r_hit) begin
                n_hit  = 1'b1;
                n_hway = r_pway;
            end
            if (!r_rd.valid && !r_free) begin
                n_free = 1'b1;
                n_fway = r_pway;
            end
        end

        if (r_out_vld && i_pop) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            hbs_pkg::BK_CLEAR: begin
                wen   = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = hbs_pkg::BK_IDLE;
                end
            end
            hbs_pkg::BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_op      = job_op;
                    n_key     = job_key;
                    n_bkt     = job_bkt;
                    n_base    = job_base;
                    ren       = 1'b1;
                    raddr     = job_base;
                    n_pend    = 1'b1;
                    n_pway    = '0;
                    n_way     = WCW'(1);
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    n_state   = (WAYS == 1) ? hbs_pkg::BK_LAST : hbs_pkg::BK_SCAN;
                end
            end
            hbs_pkg::BK_SCAN: begin
                ren    = 1'b1;
                raddr  = r_base + AW'(r_way);
                n_pend = 1'b1;
                n_pway = r_way;
                n_way  = r_way + 1'b1;
                if (r_way == WCW'(WAYS - 1)) begin
                    n_state = hbs_pkg::BK_LAST;
                end
            end
            hbs_pkg::BK_LAST: begin
                n_state = hbs_pkg::BK_DONE;
            end
            hbs_pkg::BK_DONE: begin
                if (!r_out_vld || i_pop) begin
                    n_out_vld    = 1'b1;
                    n_out.bucket = bkt_ext[3:0];
                    n_state      = hbs_pkg::BK_IDLE;
                    unique case (r_op)
                        hbs_pkg::OP_INSERT: begin
                            if (r_hit) begin
                                n_out.status = hbs_pkg::ST_DUPLICATE;
                            end else if (r_free) begin
                                wen          = 1'b1;
                                waddr        = r_base + AW'(r_fway);
                                wdata.valid  = 1'b1;
                                wdata.key    = r_key;
                                n_out.status = hbs_pkg::ST_INSERTED;
                            end else begin
                                n_out.status = hbs_pkg::ST_FULL;
                            end
                        end
                        hbs_pkg::OP_SEARCH: begin
                            n_out.status = r_hit ? hbs_pkg::ST_FOUND
                                                 : hbs_pkg::ST_NOT_FOUND;
                        end
                        hbs_pkg::OP_DELETE: begin
                            if (r_hit) begin
                                wen          = 1'b1;
                                waddr        = r_base + AW'(r_hway);
                                wdata.valid  = 1'b0;
                                wdata.key    = r_key;
                                n_out.status = hbs_pkg::ST_DELETED;
                            end else begin
                                n_out.status = hbs_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            n_out.status = hbs_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                n_state = hbs_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

[sim/bucketed_hash_set_unit_tb.sv]
// ----------------------------------------------------------------------------
// bucketed_hash_set_unit_tb: self-checking bench for the bucketed hash set
// drives insert, search, delete and unused-code requests with random gaps on both sides;
// a scoreboard keeps its own copy of the slot table, predicts status and
// bucket for every accepted request and checks results in order
// ----------------------------------------------------------------------------
module bucketed_hash_set_unit_tb;

    localparam int NUM_BUCKETS = 16;
    localparam int NUM_WAYS    = 4;
    localparam int NUM_SLOTS   = NUM_BUCKETS * NUM_WAYS;
    localparam int RAND_ITEMS  = 1100;
    localparam int HOT_KEYS    = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 16;
    localparam int MAX_REPORTS = 10;

    // the unused operation code, expected to behave as a search that misses
    localparam logic [hbs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: shadow slot table plus queue of predicted results
    // ------------------------------------------------------------------------
    class hash_set_board;
        logic [hbs_pkg::KEY_W-1:0] slot_key [NUM_SLOTS];
        bit                        slot_used[NUM_SLOTS];
        hbs_pkg::t_res             expected_q[$];
        int                        mismatches;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
        endfunction

        // update the shadow table and queue the result this request should give
        function void note_request(hbs_pkg::t_req req);
            int unsigned   bkt;
            int            hit_way;
            int            free_way;
            int            base;
            hbs_pkg::t_res res;
            bkt      = req.key % NUM_BUCKETS;
            base     = bkt * NUM_WAYS;
            hit_way  = -1;
            free_way = -1;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (slot_used[base + w] && slot_key[base + w] == req.key && hit_way < 0)
                    hit_way = w;
                if (!slot_used[base + w] && free_way < 0)
                    free_way = w;
            end
            res.bucket = bkt[hbs_pkg::BKT_W-1:0];
            case (req.operation)
                hbs_pkg::OP_INSERT: begin
                    if (hit_way >= 0) begin
                        res.status = hbs_pkg::ST_DUPLICATE;
                    end else if (free_way < 0) begin
                        res.status = hbs_pkg::ST_FULL;
                    end else begin
                        slot_key[base + free_way]  = req.key;
                        slot_used[base + free_way] = 1'b1;
                        res.status = hbs_pkg::ST_INSERTED;
                    end
                end
                hbs_pkg::OP_SEARCH: begin
                    res.status = (hit_way >= 0) ? hbs_pkg::ST_FOUND
                                                : hbs_pkg::ST_NOT_FOUND;
                end
                hbs_pkg::OP_DELETE: begin
                    if (hit_way >= 0) begin
                        slot_used[base + hit_way] = 1'b0;
                        res.status = hbs_pkg::ST_DELETED;
                    end else begin
                        res.status = hbs_pkg::ST_ABSENT;
                    end
                end
                default: begin
                    res.status = hbs_pkg::ST_NOT_FOUND;
                end
            endcase
            expected_q = {expected_q, res};
        endfunction

        function void check_result(hbs_pkg::t_res got);
            hbs_pkg::t_res exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result status %0d bucket %0d",
                                 got.status, got.bucket));
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status expected %0d got %0d (bucket %0d)",
                                 exp.status, got.status, exp.bucket));
            if (got.bucket !== exp.bucket)
                report($sformatf("bucket expected %0d got %0d",
                                 exp.bucket, got.bucket));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          pop     = 1'b0;
    hbs_pkg::t_req i_req   = '0;
    logic          full;
    logic          empty;
    hbs_pkg::t_res o_res;

    hash_set_board board;
    logic [hbs_pkg::KEY_W-1:0] hot_keys[HOT_KEYS];
    bit send_burst;
    bit recv_burst;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    bucketed_hash_set_unit #(
        .BUCKETS (NUM_BUCKETS),
        .WAYS    (NUM_WAYS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // push stays high after an accepted transaction; it drops only when the next request
    // draws a gap, when results are drained or at the end, so push never gets two assignments in a step
    task automatic send_request(logic [hbs_pkg::OP_W-1:0]  op,
                                logic [hbs_pkg::KEY_W-1:0] key);
        int gap;
        hbs_pkg::t_req req;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        req.operation = op;
        req.key       = key;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= req;
        // full seen here is the value the edge sampled
        do @(posedge i_clk); while (full);
        board.note_request(req);
    endtask

    // drop push and hold off until every predicted result has come back
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // mostly keys from a small pool crowded into five buckets, so duplicates,
    // hits and full buckets are common; the rest spread over the whole range
    function automatic logic [hbs_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80) return hot_keys[$urandom_range(0, HOT_KEYS - 1)];
        return hbs_pkg::KEY_W'($urandom());
    endfunction

    function automatic logic [hbs_pkg::OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return hbs_pkg::OP_INSERT;
        if (roll < 65) return hbs_pkg::OP_SEARCH;
        if (roll < 95) return hbs_pkg::OP_DELETE;
        return OP_UNUSED;
    endfunction

    // ------------------------------------------------------------------------
    // result side: pops forever, with its own random stalls
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int taken;
        taken = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (taken % 50 == 0) recv_burst = ($urandom_range(0, 2) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            board.check_result(o_res);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row with no transaction on either side
    // ------------------------------------------------------------------------
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hot_buckets[5];
        hot_buckets = '{1, 6, 9, 14, 15};
        board = new();
        send_burst = 1'b0;
        foreach (hot_keys[i])
            hot_keys[i] = {27'($urandom()), 4'(hot_buckets[i % 5])};

        // synchronous reset; the block then sweeps its table with full high
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes of the key, a full bucket,
        // duplicate insert, delete of an absent key, reuse of a freed way
        // and the unused operation code
        send_request(hbs_pkg::OP_SEARCH, 31'd0);
        send_request(hbs_pkg::OP_INSERT, 31'd0);
        send_request(hbs_pkg::OP_INSERT, 31'd0);
        send_request(hbs_pkg::OP_INSERT, 31'h7FFF_FFFF);
        send_request(hbs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
        send_request(hbs_pkg::OP_INSERT, 31'd16);
        send_request(hbs_pkg::OP_INSERT, 31'd32);
        send_request(hbs_pkg::OP_INSERT, 31'd48);
        send_request(hbs_pkg::OP_INSERT, 31'd64);
        send_request(hbs_pkg::OP_SEARCH, 31'd64);
        send_request(hbs_pkg::OP_DELETE, 31'd32);
        send_request(hbs_pkg::OP_DELETE, 31'd32);
        send_request(hbs_pkg::OP_INSERT, 31'd64);
        send_request(hbs_pkg::OP_SEARCH, 31'd48);
        send_request(OP_UNUSED, 31'd48);
        send_request(OP_UNUSED, 31'h7FFF_FFFF);
        send_request(hbs_pkg::OP_DELETE, 31'h7FFF_FFFF);
        send_request(hbs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
        send_request(hbs_pkg::OP_INSERT, 31'h5555_5555);
        send_request(hbs_pkg::OP_INSERT, 31'h2AAA_AAAA);
        send_request(hbs_pkg::OP_DELETE, 31'h5555_5555);
        send_request(hbs_pkg::OP_SEARCH, 31'h2AAA_AAAA);
        drain_results();

        // random part; halfway through the sender waits for a full drain
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) send_burst = ($urandom_range(0, 2) == 0);
            if (n == RAND_ITEMS / 2) drain_results();
            send_request(pick_op(), pick_key());
        end
        push <= 1'b0;

        // wait out the last results, then give stray ones time to show
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
